// File: src/ted_pkg.sv
package ted_pkg;

    // Fixed field widths
    localparam int DIST_W     = 16;
    localparam int CODE_W     = 21;
    localparam int POS_W      = 6;
    localparam int QLEN_W     = 6;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_W     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBST_W      = 3'd4;

    // Request kinds (tuser)
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_VISIT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Per-column control from the sequencer to the column unit
    typedef struct packed {
        logic step;       // a column's read data is present this cycle
        logic first_col;  // column zero
        logic first_row;  // depth one: parent is the implicit root row
    } t_col_ctl;

    // Add clamped to the distance range
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

// File: src/ted_ram.sv
module ted_ram #(
    parameter int AW = 5,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ted_col_unit.sv
module ted_col_unit #(
    parameter int CW = 6
) (
    input  logic                            i_clk,
    input  ted_pkg::t_col_ctl               i_ctl,
    input  logic [CW-1:0]                   i_col,
    input  logic [ted_pkg::DIST_W-1:0]      i_prev_rd,
    input  logic [ted_pkg::CODE_W-1:0]      i_query,
    input  logic [ted_pkg::CODE_W-1:0]      i_letter,
    input  logic [ted_pkg::WEIGHT_W-1:0]    i_ins_w,
    input  logic [ted_pkg::WEIGHT_W-1:0]    i_del_w,
    input  logic [ted_pkg::WEIGHT_W-1:0]    i_sub_w,
    output logic [ted_pkg::DIST_W-1:0]      o_cur,
    output logic [ted_pkg::DIST_W-1:0]      o_last,
    output logic [ted_pkg::DIST_W-1:0]      o_min
);
    import ted_pkg::*;

    logic [DIST_W-1:0] r_prev_last;
    logic [DIST_W-1:0] r_cur_last;
    logic [DIST_W-1:0] r_min;
    logic [DIST_W-1:0] prev_i;
    logic [DIST_W-1:0] ins_c;
    logic [DIST_W-1:0] del_c;
    logic [DIST_W-1:0] rep_c;
    logic [DIST_W-1:0] sub_w;
    logic [DIST_W-1:0] cur;

    // One cell of the new row
    always_comb begin
        prev_i = i_ctl.first_row ? DIST_W'(i_col) : i_prev_rd;
        sub_w  = (i_query == i_letter) ? '0 : DIST_W'(i_sub_w);
        ins_c  = sat_add(r_cur_last, DIST_W'(i_ins_w));
        del_c  = sat_add(prev_i, DIST_W'(i_del_w));
        rep_c  = sat_add(r_prev_last, sub_w);
        if (i_ctl.first_col) begin
            cur = sat_add(prev_i, DIST_W'(1));
        end else begin
            cur = (ins_c < del_c) ? ins_c : del_c;
            cur = (rep_c < cur) ? rep_c : cur;
        end
    end

    // Carry left neighbor, diagonal and running minimum
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_prev_last <= prev_i;
            r_cur_last  <= cur;
            r_min       <= (i_ctl.first_col || cur < r_min) ? cur : r_min;
        end
    end

    assign o_cur  = cur;
    assign o_last = r_cur_last;
    assign o_min  = r_min;

endmodule

// File: src/trie_edit_distance_row_engine_top.sv
// Channel  | Direction | Transfer condition            | Content
// s_axis   | in        | s_axis_tvalid & s_axis_tready | query load or trie node visit
// m_axis   | out       | m_axis_tvalid & m_axis_tready | distance and flags per visit
// cfg      | in        | i_cfg_valid & o_cfg_ready     | register index and value
//
// A visit keeps the input busy: it reads one row-memory column per cycle for
// query_length + 1 columns (query_length clamped to MAX_LEN), the registered read
// feeds the column unit, the last column's result is handed to the output register,
// and the block then goes idle and takes input again. A bad depth skips the row and
// goes straight to the output register.
// Reset is synchronous, active low; both memories hold garbage until written.
// A result still held in the output register keeps the next visit's result waiting and
// the input stalled until it transfers out; loads are taken while the block is idle.
module trie_edit_distance_row_engine_top #(
    parameter int MAX_LEN   = 32,
    parameter int MAX_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] position, [26:6] codepoint, [27] has_word, [31:28] zero
    input  logic [ted_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] distance, [16] match, [17] descend, [18] depth_error, [23:19] zero
    output logic [ted_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ted_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ted_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ted_pkg::*;

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RAW = DW + CW;

    // Config registers
    logic [QLEN_W-1:0]   r_qlen;
    logic [DIST_W-1:0]   r_max_dist;
    logic [WEIGHT_W-1:0] r_ins_w;
    logic [WEIGHT_W-1:0] r_del_w;
    logic [WEIGHT_W-1:0] r_sub_w;

    // Sequencer
    t_state              r_state;
    t_state              n_state;
    logic [DW-1:0]       r_row;
    logic                r_first_row;
    logic [CW-1:0]       r_len;
    logic [CW-1:0]       r_rd_col;
    logic                r_issuing;
    logic                r_cv;
    logic [CW-1:0]       r_cc;
    logic [CODE_W-1:0]   r_letter;
    logic                r_word;
    logic                r_err;

    // Output register
    logic                r_out_valid;
    logic [DIST_W-1:0]   r_o_dist;
    logic                r_o_match;
    logic                r_o_desc;
    logic                r_o_err;

    logic                in_xfer;
    logic [POS_W-1:0]    in_pos;
    logic [CODE_W-1:0]   in_code;
    logic                in_word;
    logic                bad_depth;
    logic                last_col;
    logic                out_load;
    t_col_ctl            col_ctl;
    logic [CODE_W-1:0]   q_rdata;
    logic [DIST_W-1:0]   row_rdata;
    logic [DIST_W-1:0]   cur;
    logic [DIST_W-1:0]   last;
    logic [DIST_W-1:0]   row_min;

    assign in_pos    = s_axis_tdata[POS_W-1:0];
    assign in_code   = s_axis_tdata[POS_W +: CODE_W];
    assign in_word   = s_axis_tdata[POS_W + CODE_W];
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign bad_depth = (in_pos == '0) || (32'(in_pos) > MAX_DEPTH);
    assign last_col  = r_cv && (r_cc == r_len);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Config write port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen     <= '0;
            r_max_dist <= DIST_W'(2);
            r_ins_w    <= WEIGHT_W'(1);
            r_del_w    <= WEIGHT_W'(1);
            r_sub_w    <= WEIGHT_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUERY_LENGTH: r_qlen     <= i_cfg_data[QLEN_W-1:0];
                CFG_MAX_DISTANCE: r_max_dist <= i_cfg_data;
                CFG_INSERT_W:     r_ins_w    <= i_cfg_data[WEIGHT_W-1:0];
                CFG_DELETE_W:     r_del_w    <= i_cfg_data[WEIGHT_W-1:0];
                CFG_SUBST_W:      r_sub_w    <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && s_axis_tuser == REQ_VISIT) begin
                    n_state = bad_depth ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (last_col) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Column issue and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_cv      <= 1'b0;
        end else begin
            r_cv <= r_issuing;
            if (in_xfer && s_axis_tuser == REQ_VISIT) begin
                r_issuing <= !bad_depth;
            end else if (r_issuing && r_rd_col == r_len) begin
                r_issuing <= 1'b0;
            end
        end
    end

    // Per-visit payload
    always_ff @(posedge i_clk) begin
        r_cc <= r_rd_col;
        if (in_xfer && s_axis_tuser == REQ_VISIT) begin
            r_rd_col    <= '0;
            r_row       <= DW'(in_pos - POS_W'(1));
            r_first_row <= (in_pos == POS_W'(1));
            r_len       <= (32'(r_qlen) > MAX_LEN) ? CW'(MAX_LEN) : CW'(r_qlen);
            r_letter    <= in_code;
            r_word      <= in_word;
            r_err       <= bad_depth;
        end else if (r_issuing && r_rd_col != r_len) begin
            r_rd_col <= r_rd_col + CW'(1);
        end
    end

    // Query store
    ted_ram #(.AW(QAW), .DW(CODE_W)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && s_axis_tuser == REQ_LOAD && 32'(in_pos) < MAX_LEN),
        .i_waddr (QAW'(in_pos)),
        .i_wdata (in_code),
        .i_re    (r_issuing),
        .i_raddr (QAW'(r_rd_col - CW'(1))),
        .o_rdata (q_rdata)
    );

    // Row store: row index is depth minus one, parent read, node written
    ted_ram #(.AW(RAW), .DW(DIST_W)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_cv),
        .i_waddr ({r_row, r_cc}),
        .i_wdata (cur),
        .i_re    (r_issuing && !r_first_row),
        .i_raddr ({r_row - DW'(1), r_rd_col}),
        .o_rdata (row_rdata)
    );

    assign col_ctl.step      = r_cv;
    assign col_ctl.first_col = (r_cc == '0);
    assign col_ctl.first_row = r_first_row;

    ted_col_unit #(.CW(CW)) u_col (
        .i_clk     (i_clk),
        .i_ctl     (col_ctl),
        .i_col     (r_cc),
        .i_prev_rd (row_rdata),
        .i_query   (q_rdata),
        .i_letter  (r_letter),
        .i_ins_w   (r_ins_w),
        .i_del_w   (r_del_w),
        .i_sub_w   (r_sub_w),
        .o_cur     (cur),
        .o_last    (last),
        .o_min     (row_min)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_dist  <= r_err ? '0 : last;
            r_o_match <= !r_err && r_word && (last <= r_max_dist);
            r_o_desc  <= !r_err && (row_min <= r_max_dist);
            r_o_err   <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - DIST_W - 3)'(0), r_o_err, r_o_desc, r_o_match,
                            r_o_dist};

endmodule

// File: src/ted_checker.sv
module ted_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [ted_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import ted_pkg::*;

    // A visit occupies the block: no transfer in on the next cycle
    a_visit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_VISIT |=> !s_axis_tready)
        else $error("input ready right after a visit transfer");

    // A load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result appeared after a query load");

    // A depth error carries zero distance and flags
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[DIST_W + 2] |-> m_axis_tdata[DIST_W + 1:0] == '0)
        else $error("depth error result with nonzero fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind trie_edit_distance_row_engine_top ted_checker u_ted_checker (.*);

// File: tb/sv/trie_edit_distance_row_engine_top_tb.sv
module trie_edit_distance_row_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ted_pkg::*;

    localparam int ROW_LEN     = 32;
    localparam int TRIE_DEPTH  = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CODE_W-1:0]    CODE_MAX   = 21'h10FFFF;
    localparam logic [CODE_W-1:0]    LETTER_A   = 21'h61;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic              req_type;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] codepoint;
        logic              has_word;
    } t_request;

    // Same bit order as m_axis_tdata[18:0]
    typedef struct packed {
        logic              depth_error;
        logic              descend;
        logic              match;
        logic [DIST_W-1:0] distance;
    } t_result;

    typedef struct packed {
        logic [QLEN_W-1:0]   qlen;
        logic [DIST_W-1:0]   maxd;
        logic [WEIGHT_W-1:0] ins;
        logic [WEIGHT_W-1:0] del;
        logic [WEIGHT_W-1:0] sub;
    } t_settings;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: register copies, query and per-depth rows
    logic [QLEN_W-1:0]   qlen_reg = '0;
    logic [DIST_W-1:0]   maxd_reg = 16'd2;
    logic [WEIGHT_W-1:0] ins_w = 8'd1;
    logic [WEIGHT_W-1:0] del_w = 8'd1;
    logic [WEIGHT_W-1:0] sub_w = 8'd1;
    logic [CODE_W-1:0]   query_mem [ROW_LEN];
    logic [DIST_W-1:0]   row_mem [TRIE_DEPTH+1][ROW_LEN+1];
    int                  row_cols [TRIE_DEPTH+1] = '{default: -1};

    t_result expected_node_results [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_request = 1'b0;
    bit      hold_seen = 1'b0;
    int      hold_left = 0;
    int      walk_depth = 0;
    bit      walk_descend = 1'b0;

    trie_edit_distance_row_engine_top #(
        .MAX_LEN   (ROW_LEN),
        .MAX_DEPTH (TRIE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trie_edit_distance_row_engine_top_tb failed");
            $finish;
        end
    end

    function automatic logic [DIST_W-1:0] clamp_add(input logic [DIST_W-1:0] a,
                                                    input logic [DIST_W-1:0] b);
        logic [DIST_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return (total > {1'b0, {DIST_W{1'b1}}}) ? {DIST_W{1'b1}} : total[DIST_W-1:0];
    endfunction

    function automatic int active_len();
        return (qlen_reg > ROW_LEN) ? ROW_LEN : int'(qlen_reg);
    endfunction

    // Applies one transfer to the predictor state; loads give no result
    function automatic t_result compute_node_row(input t_request req, output bit produced);
        t_result           res;
        logic [DIST_W-1:0] parent [ROW_LEN+1];
        logic [DIST_W-1:0] ins_cost, del_cost, rep_cost, sub_cost, low, cell_val;
        int                len, d;
        res = '0;
        produced = 1'b0;
        if (req.req_type == REQ_LOAD) begin
            if (req.position < ROW_LEN) query_mem[req.position] = req.codepoint;
            return res;
        end
        produced = 1'b1;
        d = req.position;
        if (d == 0 || d > TRIE_DEPTH) begin
            res.depth_error = 1'b1;
            return res;
        end
        len = active_len();
        // depth one reads the implicit root row 0, 1, 2, ...
        for (int i = 0; i <= len; i++)
            parent[i] = (d == 1) ? DIST_W'(i) : row_mem[d-1][i];
        row_mem[d][0] = clamp_add(parent[0], 16'd1);
        low = row_mem[d][0];
        for (int i = 1; i <= len; i++) begin
            sub_cost = (query_mem[i-1] == req.codepoint) ? '0 : DIST_W'(sub_w);
            ins_cost = clamp_add(row_mem[d][i-1], DIST_W'(ins_w));
            del_cost = clamp_add(parent[i], DIST_W'(del_w));
            rep_cost = clamp_add(parent[i-1], sub_cost);
            cell_val = (ins_cost < del_cost) ? ins_cost : del_cost;
            if (rep_cost < cell_val) cell_val = rep_cost;
            row_mem[d][i] = cell_val;
            if (cell_val < low) low = cell_val;
        end
        row_cols[d] = len;
        res.distance = row_mem[d][len];
        res.match    = req.has_word && (res.distance <= maxd_reg);
        res.descend  = (low <= maxd_reg);
        return res;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[18:0];
            if (expected_node_results.size() == 0) begin
                $error("unexpected result: distance %0d depth_error %0d",
                       got.distance, got.depth_error);
                fail_count++;
            end else begin
                want = expected_node_results.pop_front();
                if (got.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, got.distance);
                    fail_count++;
                end
                if (got.match !== want.match) begin
                    $error("match: expected %0d, got %0d", want.match, got.match);
                    fail_count++;
                end
                if (got.descend !== want.descend) begin
                    $error("descend: expected %0d, got %0d", want.descend, got.descend);
                    fail_count++;
                end
                if (got.depth_error !== want.depth_error) begin
                    $error("depth_error: expected %0d, got %0d",
                           want.depth_error, got.depth_error);
                    fail_count++;
                end
            end
        end
    end

    // Receiver ready; a long hold-off starts when the test flips the request bit
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One input transfer; the prediction is made at the accepting edge
    task automatic send_item(input t_request req, output t_result res, output bit produced);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, req.has_word, req.codepoint, req.position};
        s_axis_tuser  <= req.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        res = compute_node_row(req, produced);
        if (produced) expected_node_results.push_back(res);
    endtask

    task automatic load(input int pos, input logic [CODE_W-1:0] letter);
        t_request req;
        t_result  res;
        bit       produced;
        req = '{REQ_LOAD, POS_W'(pos), letter, 1'b0};
        send_item(req, res, produced);
    endtask

    task automatic visit(input int depth, input logic [CODE_W-1:0] letter, input bit word);
        t_request req;
        t_result  res;
        bit       produced;
        req = '{REQ_VISIT, POS_W'(depth), letter, word};
        send_item(req, res, produced);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_node_results.size() != 0);
    endtask

    // Idle the block: all results in, then room for a trailing load
    task automatic quiesce();
        drain_results();
        repeat (ROW_LEN + 8) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_settings s);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_UNUSED, CFG_QUERY_LENGTH, CFG_MAX_DISTANCE,
                CFG_INSERT_W, CFG_DELETE_W, CFG_SUBST_W};
        val = '{16'hFFFF, CFG_DATA_W'(s.qlen), s.maxd,
                CFG_DATA_W'(s.ins), CFG_DATA_W'(s.del), CFG_DATA_W'(s.sub)};
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                CFG_QUERY_LENGTH: qlen_reg = val[i][QLEN_W-1:0];
                CFG_MAX_DISTANCE: maxd_reg = val[i];
                CFG_INSERT_W:     ins_w    = val[i][WEIGHT_W-1:0];
                CFG_DELETE_W:     del_w    = val[i][WEIGHT_W-1:0];
                CFG_SUBST_W:      sub_w    = val[i][WEIGHT_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a small alphabet so that letters match the query often
    function automatic logic [CODE_W-1:0] draw_letter();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return LETTER_A + CODE_W'($urandom_range(0, 3));
        if (pick < 92) return CODE_W'($urandom_range(0, CODE_MAX));
        return (pick < 96) ? '0 : CODE_MAX;
    endfunction

    task automatic load_query(input int len);
        for (int i = 0; i < len; i++) load(i, draw_letter());
    endtask

    // Depth-first walk: descend only where the last row allowed it,
    // with a few stray loads and bad depths mixed in
    task automatic walk_trie(input int count);
        t_request req;
        t_result  res;
        bit       produced;
        int       eff_len, d, pick;
        for (int k = 0; k < count; k++) begin
            eff_len = active_len();
            pick = $urandom_range(0, 99);
            d = 0;
            req.has_word = ($urandom_range(0, 99) < 35);
            if (pick < 5) begin
                req.req_type  = REQ_LOAD;
                req.position  = POS_W'($urandom_range(0, 63));
                req.codepoint = draw_letter();
            end else if (pick < 9) begin
                req.req_type  = REQ_VISIT;
                req.position  = ($urandom_range(0, 3) == 0) ?
                                '0 : POS_W'($urandom_range(TRIE_DEPTH + 1, 63));
                req.codepoint = CODE_W'($urandom_range(0, CODE_MAX));
            end else begin
                if (walk_descend && walk_depth < TRIE_DEPTH && $urandom_range(0, 99) < 75)
                    d = walk_depth + 1;
                else if (walk_depth == 0)
                    d = 1;
                else
                    d = $urandom_range(1, walk_depth);
                // parent row must cover every column of the current length
                while (d > 1 && row_cols[d-1] < eff_len) d--;
                req.req_type = REQ_VISIT;
                req.position = POS_W'(d);
                if (d <= eff_len && $urandom_range(0, 99) < 55)
                    req.codepoint = query_mem[d-1];
                else
                    req.codepoint = draw_letter();
            end
            send_item(req, res, produced);
            if (d != 0) begin
                walk_depth   = d;
                walk_descend = res.descend;
            end
        end
    endtask

    function automatic t_settings phase_settings(input int p);
        t_settings s;
        case (p)
            0: s = '{qlen: 6'd32, maxd: 16'hFFFF, ins: 8'hFF, del: 8'hFF, sub: 8'hFF};
            4: s = '{qlen: 6'd63, maxd: 16'd0, ins: 8'd0, del: 8'd0, sub: 8'd0};
            8: s = '{qlen: 6'd0, maxd: 16'd0, ins: 8'hFF, del: 8'd0, sub: 8'hFF};
            default: begin
                s.qlen = ($urandom_range(0, 99) < 85) ?
                         QLEN_W'($urandom_range(1, 32)) : QLEN_W'($urandom_range(33, 63));
                s.maxd = ($urandom_range(0, 99) < 70) ?
                         DIST_W'($urandom_range(0, 12)) : DIST_W'($urandom_range(0, 65535));
                s.ins  = ($urandom_range(0, 99) < 70) ?
                         WEIGHT_W'($urandom_range(0, 3)) : WEIGHT_W'($urandom_range(0, 255));
                s.del  = ($urandom_range(0, 99) < 70) ?
                         WEIGHT_W'($urandom_range(0, 3)) : WEIGHT_W'($urandom_range(0, 255));
                s.sub  = ($urandom_range(0, 99) < 70) ?
                         WEIGHT_W'($urandom_range(0, 3)) : WEIGHT_W'($urandom_range(0, 255));
            end
        endcase
        return s;
    endfunction

    // Default registers, empty query, bad depths
    task automatic test_reset_defaults();
        visit(1, LETTER_A, 1'b1);
        visit(0, LETTER_A, 1'b1);
        visit(TRIE_DEPTH + 1, '0, 1'b0);
        visit(63, CODE_MAX, 1'b1);
    endtask

    // Extreme letters, plus loads past the end of the query store
    task automatic test_query_load();
        load(0, '0);
        load(1, CODE_MAX);
        load(2, LETTER_A);
        load(3, LETTER_A + CODE_W'(1));
        load(ROW_LEN, LETTER_A + CODE_W'(25));
        load(63, CODE_MAX);
        quiesce();
        apply_settings('{qlen: 6'd4, maxd: 16'd2, ins: 8'd1, del: 8'd1, sub: 8'd1});
    endtask

    // Exact path, siblings, one level past the query, backtrack
    task automatic test_directed_walk();
        visit(1, '0, 1'b0);
        visit(2, CODE_MAX, 1'b0);
        visit(3, LETTER_A, 1'b0);
        visit(4, LETTER_A + CODE_W'(1), 1'b1);
        visit(4, LETTER_A + CODE_W'(2), 1'b1);
        visit(5, LETTER_A, 1'b1);
        visit(2, LETTER_A, 1'b1);
        visit(3, LETTER_A, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_request = ~hold_request;
        walk_trie(30);
        drain_results();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_pause_until_drained();
        set_idling(23, 23);
        walk_trie(15);
        drain_results();
        walk_trie(15);
    endtask

    task automatic test_random_walks();
        for (int p = 0; p < 12; p++) begin
            case (p / 3)
                0: set_idling(0, 0);
                1: set_idling(65, 0);
                2: set_idling(0, 65);
                default: set_idling(23, 23);
            endcase
            quiesce();
            apply_settings(phase_settings(p));
            load_query(active_len());
            walk_depth = 0;
            walk_trie(60);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_query_load();
        test_directed_walk();
        test_output_backpressure();
        test_pause_until_drained();
        test_random_walks();
        drain_results();
        repeat (ROW_LEN + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("trie_edit_distance_row_engine_top_tb passed");
        end else begin
            $display("trie_edit_distance_row_engine_top_tb failed");
        end
        $finish;
    end

endmodule
